// File: rtl/core/reciprocal_lattice_vectors_assert.svh
// assertion macros shared by the rtl
`ifndef RECIPROCAL_LATTICE_VECTORS_ASSERT_SVH
`define RECIPROCAL_LATTICE_VECTORS_ASSERT_SVH

`ifndef SYNTHESIS
`define RLV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLV_ASSERT(lbl, clk, rst_n, prop, msg)
`define RLV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/rlv_pkg.sv
package rlv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SAT      = 2'd1,
        STATUS_SINGULAR = 2'd2
    } status_t;

    function automatic int byte_pad(input int n);
        return ((n + 7) / 8) * 8;
    endfunction

endpackage

// File: rtl/core/rlv_div.sv
module rlv_div #(
    parameter int W  = rlv_pkg::DATA_WIDTH,
    parameter int NW = 3 * rlv_pkg::DATA_WIDTH + 1 + rlv_pkg::FRAC_BITS,
    parameter int DW = 3 * rlv_pkg::DATA_WIDTH + 3
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_mag,
    input  logic [DW-1:0] den_mag,
    output logic [W:0]    quot,
    output logic          ovf
);

    localparam int QW   = W + 1;
    localparam int RW   = ((NW > DW) ? NW : DW) + 1;
    localparam int CMPW = ((NW > DW + W) ? NW : DW + W) + 1;

    logic [RW-1:0] rem_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic          ovf_reg [0:QW];

    // first stage: overflow check and top part of the dividend
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= CMPW'(num_mag) >= (CMPW'(den_mag) << W);
            rem_reg[0] <= RW'(num_mag >> W);
            low_reg[0] <= {num_mag[W-1:0], 1'b0};
            q_reg[0]   <= '0;
            den_reg[0] <= den_mag;
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= QW; i++) begin : g_step
        logic [RW-1:0] trial;
        logic          take;
        assign trial = {rem_reg[i-1][RW-2:0], low_reg[i-1][QW-1]};
        assign take  = trial >= RW'(den_reg[i-1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= take ? (trial - RW'(den_reg[i-1])) : trial;
                q_reg[i]   <= {q_reg[i-1][QW-2:0], take};
                low_reg[i] <= {low_reg[i-1][QW-2:0], 1'b0};
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quot = q_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule

// File: rtl/core/reciprocal_lattice_vectors.sv
// Reciprocal lattice vectors of a 3d direct basis, fixed point.
// Input stream: one transaction carries p1, p2, p3 (nine signed components,
// FRAC_BITS fraction bits each) in s_axis_tdata. Output stream: one
// transaction per input with b1, b2, b3 in m_axis_tdata and a status code
// in m_axis_tuser (ok, some component saturated, singular basis).
// The factor k is written through cfg_wr_en / cfg_wr_data; the user must
// write k only while the block is idle (the block does not enforce this); it resets to 1.0.
// The pipeline has five stages of products and sums, a divider of
// DATA_WIDTH + 2 stages that retires one quotient bit per stage after its
// first, and the output register. One transaction is accepted every cycle
// unless the receiver stalls with the output register full.
// Reset empties the pipeline and restores the factor.
// When the receiver stalls with the output register full, the whole
// pipeline holds and s_axis_tready drops; nothing is lost or repeated.
`include "reciprocal_lattice_vectors_assert.svh"

module reciprocal_lattice_vectors #(
    parameter int DATA_WIDTH = rlv_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = rlv_pkg::FRAC_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, zero pad
    input  logic [rlv_pkg::byte_pad(9*DATA_WIDTH)-1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // b1_x, b1_y, b1_z, b2_x, b2_y, b2_z, b3_x, b3_y, b3_z, zero pad
    output logic [rlv_pkg::byte_pad(9*DATA_WIDTH)-1:0] m_axis_tdata,
    // status
    output logic [1:0]                              m_axis_tuser,
    input  logic                                    cfg_wr_en,
    input  logic [DATA_WIDTH-1:0]                   cfg_wr_data
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TDW = rlv_pkg::byte_pad(9 * W);
    localparam int PW  = 2 * W;
    localparam int CW  = 2 * W + 1;
    localparam int HW  = 2 * W + 1;
    localparam int TW  = 3 * W + 1;
    localparam int NW  = TW + F;
    localparam int VW  = 3 * W + 3;
    localparam int QW  = W + 1;
    localparam int DL  = W + 2;

    logic en;
    logic signed [W-1:0] cfg_reg;

    logic v_reg [1:5];
    logic v_sh_reg [0:DL-1];
    logic m_valid_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= W'(1) << F;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= 5; i++) v_reg[i] <= 1'b0;
            for (int i = 0; i < DL; i++) v_sh_reg[i] <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg[1] <= s_axis_tvalid;
            for (int i = 2; i <= 5; i++) v_reg[i] <= v_reg[i-1];
            v_sh_reg[0] <= v_reg[5];
            for (int i = 1; i < DL; i++) v_sh_reg[i] <= v_sh_reg[i-1];
            m_valid_reg <= v_sh_reg[DL-1];
        end
    end

    // stage 1: cross products terms
    logic signed [W-1:0]  p_in [0:8];
    logic signed [PW-1:0] px_reg [0:8];
    logic signed [PW-1:0] py_reg [0:8];
    logic signed [W-1:0]  p1_reg1 [0:2];
    logic signed [W-1:0]  p1_reg2 [0:2];

    for (genvar i = 0; i < 9; i++) begin : g_in
        assign p_in[i] = s_axis_tdata[i*W +: W];
    end

    for (genvar g = 0; g < 3; g++) begin : g_pair
        for (genvar j = 0; j < 3; j++) begin : g_comp
            localparam int U = (g + 1) % 3;
            localparam int V = (g + 2) % 3;
            localparam int A = (j + 1) % 3;
            localparam int B = (j + 2) % 3;
            always_ff @(posedge aclk) begin
                if (en) begin
                    px_reg[3*g+j] <= p_in[3*U+A] * p_in[3*V+B];
                    py_reg[3*g+j] <= p_in[3*U+B] * p_in[3*V+A];
                end
            end
        end
    end

    // stage 2: cross differences
    logic signed [CW-1:0] c_reg [0:8];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p1_reg1[i] <= p_in[i];
                p1_reg2[i] <= p1_reg1[i];
            end
            for (int i = 0; i < 9; i++) begin
                c_reg[i] <= CW'(px_reg[i]) - CW'(py_reg[i]);
            end
        end
    end

    // stage 3: split products, low half unsigned, high half signed
    logic signed [HW-1:0] kp_lo_reg [0:8];
    logic signed [HW-1:0] kp_hi_reg [0:8];
    logic signed [HW-1:0] vp_lo_reg [0:2];
    logic signed [HW-1:0] vp_hi_reg [0:2];

    for (genvar i = 0; i < 9; i++) begin : g_kmul
        logic signed [W:0] c_lo;
        logic signed [W:0] c_hi;
        assign c_lo = $signed({1'b0, c_reg[i][W-1:0]});
        assign c_hi = $signed(c_reg[i][CW-1:W]);
        always_ff @(posedge aclk) begin
            if (en) begin
                kp_lo_reg[i] <= cfg_reg * c_lo;
                kp_hi_reg[i] <= cfg_reg * c_hi;
            end
        end
        if (i < 3) begin : g_vmul
            always_ff @(posedge aclk) begin
                if (en) begin
                    vp_lo_reg[i] <= p1_reg2[i] * c_lo;
                    vp_hi_reg[i] <= p1_reg2[i] * c_hi;
                end
            end
        end
    end

    // stage 4: numerators and volume
    logic signed [NW-1:0] num_reg [0:8];
    logic signed [VW-1:0] vol_reg;
    logic signed [TW-1:0] vt [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_vt
        assign vt[i] = (TW'(vp_hi_reg[i]) <<< W) + TW'(vp_lo_reg[i]);
    end

    for (genvar i = 0; i < 9; i++) begin : g_num
        logic signed [TW-1:0] kt;
        assign kt = (TW'(kp_hi_reg[i]) <<< W) + TW'(kp_lo_reg[i]);
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[i] <= NW'(kt) <<< F;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vol_reg <= VW'(vt[0]) + VW'(vt[1]) + VW'(vt[2]);
        end
    end

    // stage 5: magnitudes and signs
    logic [NW-1:0] num_mag_reg [0:8];
    logic [VW-1:0] vol_mag_reg;
    logic [8:0]    neg_reg;
    logic          sing_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                num_mag_reg[i] <= num_reg[i][NW-1] ? NW'(-num_reg[i]) : NW'(num_reg[i]);
                neg_reg[i]     <= num_reg[i][NW-1] ^ vol_reg[VW-1];
            end
            vol_mag_reg <= vol_reg[VW-1] ? VW'(-vol_reg) : VW'(vol_reg);
            sing_reg    <= vol_reg == '0;
        end
    end

    // divider lanes
    logic [QW-1:0] quot [0:8];
    logic [8:0]    ovf;

    for (genvar i = 0; i < 9; i++) begin : g_div
        rlv_div #(
            .W  (W),
            .NW (NW),
            .DW (VW)
        ) u_div (
            .aclk    (aclk),
            .en      (en),
            .num_mag (num_mag_reg[i]),
            .den_mag (vol_mag_reg),
            .quot    (quot[i]),
            .ovf     (ovf[i])
        );
    end

    logic [8:0] neg_sh_reg  [0:DL-1];
    logic       sing_sh_reg [0:DL-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_sh_reg[0]  <= neg_reg;
            sing_sh_reg[0] <= sing_reg;
            for (int i = 1; i < DL; i++) begin
                neg_sh_reg[i]  <= neg_sh_reg[i-1];
                sing_sh_reg[i] <= sing_sh_reg[i-1];
            end
        end
    end

    // rounding, saturation and sign
    logic [9*W-1:0]        res;
    logic [8:0]            sat;
    rlv_pkg::status_t      status;
    logic [TDW-1:0]        tdata_reg;
    logic [1:0]            tuser_reg;

    always_comb begin
        logic [QW:0]   rq;
        logic [QW-1:0] q;
        logic [QW-1:0] lim;
        logic [W-1:0]  mag;
        res = '0;
        sat = '0;
        for (int i = 0; i < 9; i++) begin
            rq  = (QW+1)'(quot[i]) + (QW+1)'(1);
            q   = rq[QW:1];
            lim = neg_sh_reg[DL-1][i] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
            sat[i] = ovf[i] || (q > lim);
            mag = sat[i] ? lim[W-1:0] : q[W-1:0];
            res[i*W +: W] = neg_sh_reg[DL-1][i] ? (W'(0) - mag) : mag;
        end
        if (sing_sh_reg[DL-1]) begin
            status = rlv_pkg::STATUS_SINGULAR;
        end else if (|sat) begin
            status = rlv_pkg::STATUS_SAT;
        end else begin
            status = rlv_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= sing_sh_reg[DL-1] ? '0 : TDW'(res);
            tuser_reg <= status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

    `RLV_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_axis_tvalid, "output valid after reset")
    `RLV_ASSERT(a_singular_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser == rlv_pkg::STATUS_SINGULAR |-> m_axis_tdata == '0, "singular basis with nonzero data")
    `RLV_ASSERT(a_stall_cause, aclk, aresetn, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

endmodule
